// ----- src/sbe_pkg.sv -----
// ----------------------------------------------------------------------------
// sbe_pkg: shared types and constants of the synthesizer BCD bus word encoder
// Holds the request and result structs, the record that passes from the
// converter to the word emitter, queue status and the bus word constants.
// ----------------------------------------------------------------------------
package sbe_pkg;

  // request and result payloads
  typedef struct packed {
    logic [13:0] base_freq;
    logic [26:0] offset_freq;
    logic [1:0]  channel;
    logic        set_both;
  } sbe_req_t;

  typedef struct packed {
    logic [15:0] bus_word;
    logic        last_word;
  } sbe_res_t;

  // converted transaction, front to back
  typedef struct packed {
    logic [27:0] ofs_bcd;   // seven BCD digits of offset / 10
    logic [15:0] main_bcd;  // four BCD digits of the base frequency
    logic        dec_sel;   // decoupler channel: register pair 2/3
    logic        set_both;
  } sbe_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } sbe_qstat_t;

  // channel codes
  localparam logic [1:0] CH_TX  = 2'd1;
  localparam logic [1:0] CH_DEC = 2'd2;

  // bus word fields
  localparam logic [15:0] INIT_PREFIX = 16'ha000;
  localparam logic [15:0] SEQ_PREFIX  = 16'h9000;
  localparam logic [1:0]  INIT_LOW    = 2'b11;
  localparam logic [3:0]  BOARD_ADDR  = 4'd7;

  // divide-by-ten reciprocals
  localparam logic [31:0] RECIP_OFS  = 32'hcccc_cccd;  // >> 35, exact below 2^32
  localparam logic [15:0] RECIP_BASE = 16'hcccd;       // >> 19, exact below 81920

  // converter: one drop step plus seven offset digits
  localparam logic [2:0] STEP_LAST = 3'd7;

  // emitter word indexes
  localparam logic [3:0] IDX_RUN1     = 4'd5;
  localparam logic [3:0] IDX_LAST_ONE = 4'd4;
  localparam logic [3:0] IDX_LAST_TWO = 4'd9;

endpackage

// ----- src/sbe_front.sv -----
// ----------------------------------------------------------------------------
// sbe_front: request intake and BCD converter
// Accepts a request, drops channels without a register pair, and splits the
// offset and base frequency into decimal digits, one digit per cycle each.
// ----------------------------------------------------------------------------
module sbe_front import sbe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  sbe_req_t   req_i,
  input  sbe_qstat_t qstat_i,
  output logic       push_o,
  output sbe_rec_t   rec_o
);

  logic        active_q;
  logic [2:0]  step_q;
  logic [26:0] ofs_q;
  logic [13:0] base_q;
  logic [23:0] obcd_q;
  logic [15:0] mbcd_q;
  logic        sel_q;
  logic        both_q;

  logic        last_step;
  logic        adv;
  logic        load;
  logic        chan_ok;

  logic [58:0] ofs_prod;
  logic [23:0] ofs_quo;
  logic [26:0] ofs_diff;
  logic [3:0]  ofs_rem;
  logic [29:0] base_prod;
  logic [10:0] base_quo;
  logic [13:0] base_diff;
  logic [3:0]  base_rem;

  // one divide-by-ten per value per cycle
  assign ofs_prod  = {32'd0, ofs_q} * {27'd0, RECIP_OFS};
  assign ofs_quo   = ofs_prod[58:35];
  assign ofs_diff  = ofs_q - ({ofs_quo, 3'b000} + {2'b00, ofs_quo, 1'b0});
  assign ofs_rem   = ofs_diff[3:0];

  assign base_prod = {16'd0, base_q} * {14'd0, RECIP_BASE};
  assign base_quo  = base_prod[29:19];
  assign base_diff = base_q - ({base_quo, 3'b000} + {2'b00, base_quo, 1'b0});
  assign base_rem  = base_diff[3:0];

  assign last_step = (step_q == STEP_LAST);
  assign push_o    = active_q && last_step && !qstat_i.full;
  assign adv       = active_q && (!last_step || !qstat_i.full);
  assign busy      = active_q && !push_o;
  assign chan_ok   = (req_i.channel == CH_TX) || (req_i.channel == CH_DEC);
  assign load      = start && !busy && chan_ok;

  assign rec_o.ofs_bcd  = {ofs_rem, obcd_q};
  assign rec_o.main_bcd = mbcd_q;
  assign rec_o.dec_sel  = sel_q;
  assign rec_o.set_both = both_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      step_q   <= '0;
    end else if (load) begin
      active_q <= 1'b1;
      step_q   <= '0;
    end else if (push_o) begin
      active_q <= 1'b0;
    end else if (adv) begin
      step_q   <= step_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ofs_q  <= req_i.offset_freq;
      base_q <= req_i.base_freq;
      sel_q  <= (req_i.channel == CH_DEC);
      both_q <= req_i.set_both;
    end else if (adv) begin
      ofs_q  <= {3'b000, ofs_quo};
      base_q <= {3'b000, base_quo};
      // first remainder digit is the dropped tenths digit
      if (step_q != 3'd0) begin
        obcd_q <= {ofs_rem, obcd_q[23:4]};
      end
      if (!step_q[2]) begin
        mbcd_q <= {base_rem, mbcd_q[15:4]};
      end
    end
  end

endmodule

// ----- src/sbe_queue.sv -----
// ----------------------------------------------------------------------------
// sbe_queue: two-entry record queue
// Decouples the converter from the word emitter.
// ----------------------------------------------------------------------------
module sbe_queue import sbe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  sbe_rec_t   rec_i,
  input  logic       pop_i,
  output sbe_rec_t   rec_o,
  output sbe_qstat_t stat_o
);

  sbe_rec_t   entry_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;

  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);
  assign rec_o        = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= rec_i;
    end
  end

endmodule

// ----- src/sbe_back.sv -----
// ----------------------------------------------------------------------------
// sbe_back: bus word emitter
// Takes one record from the queue and sends its five or ten bus words, one
// per cycle, through a registered output.
// ----------------------------------------------------------------------------
module sbe_back import sbe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  sbe_rec_t   rec_i,
  input  sbe_qstat_t qstat_i,
  output logic       pop_o,
  output logic       strobe_o,
  output sbe_res_t   res_o
);

  sbe_rec_t    cur_q;
  logic        active_q;
  logic [3:0]  idx_q;
  logic        strobe_q;
  sbe_res_t    res_q;

  logic        run;
  logic [2:0]  pos;
  logic [1:0]  byte_sel;
  logic [31:0] data32;
  logic [7:0]  data_byte;
  logic [1:0]  reg_sel;
  logic        is_last;
  logic [15:0] word;

  assign run       = (idx_q >= IDX_RUN1);
  assign pos       = run ? 3'(idx_q - IDX_RUN1) : idx_q[2:0];
  assign byte_sel  = 2'(pos - 3'd1);
  assign data32    = run ? ~{cur_q.main_bcd, 16'h0000} : {4'h0, cur_q.ofs_bcd};
  assign data_byte = data32[{byte_sel, 3'b000} +: 8];
  assign reg_sel   = {cur_q.dec_sel, run};
  assign is_last   = cur_q.set_both ? (idx_q == IDX_LAST_TWO) : (idx_q == IDX_LAST_ONE);

  always_comb begin
    if (pos == 3'd0) begin
      word = INIT_PREFIX | {4'h0, BOARD_ADDR, 8'h00} | {12'h000, reg_sel, INIT_LOW};
    end else begin
      word = SEQ_PREFIX | {4'h0, BOARD_ADDR, data_byte};
    end
  end

  assign pop_o    = !qstat_i.empty && (!active_q || is_last);
  assign strobe_o = strobe_q;
  assign res_o    = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      idx_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= active_q;
      if (pop_o) begin
        active_q <= 1'b1;
        idx_q    <= '0;
      end else if (active_q && is_last) begin
        active_q <= 1'b0;
      end else if (active_q) begin
        idx_q    <= idx_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= rec_i;
    end
    res_q.bus_word  <= word;
    res_q.last_word <= is_last;
  end

endmodule

// ----- src/synth_bcd_bus_word_encoder_top.sv -----
// ----------------------------------------------------------------------------
// synth_bcd_bus_word_encoder_top: BCD bus word encoder for a synthesizer board
// Turns a frequency request into the 16-bit init and byte words of the board.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Channel 1 or 2
// produces five bus words (init word, then the four bytes of the BCD offset,
// low byte first), or ten when set_both is set (a second run carries the
// inverted main frequency word); channel 0 or 3 is taken and produces nothing.
// Each word appears on res_o for exactly one cycle with strobe_o high, back to
// back, and last_word marks the final word of the transaction. The receiver
// cannot stall the block: words are always delivered at one per cycle.
// Conversion: the converter makes one divide-by-ten step per cycle (a
// tenths-digit drop plus seven offset digits), holding at its last step
// while the two-entry queue is full, and can take the next transaction in
// the cycle its result enters the queue. The emitter sends one word per
// cycle.
module synth_bcd_bus_word_encoder_top import sbe_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  sbe_req_t req_i,
  output logic     strobe_o,
  output sbe_res_t res_o
);

  logic       push;
  logic       pop;
  sbe_rec_t   rec_in;
  sbe_rec_t   rec_out;
  sbe_qstat_t qstat;

  // intake and digit conversion
  sbe_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .req_i   (req_i),
    .qstat_i (qstat),
    .push_o  (push),
    .rec_o   (rec_in)
  );

  // short queue lets conversion run ahead of word output
  sbe_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .rec_i  (rec_in),
    .pop_i  (pop),
    .rec_o  (rec_out),
    .stat_o (qstat)
  );

  // word sequencing and registered output
  sbe_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rec_i    (rec_out),
    .qstat_i  (qstat),
    .pop_o    (pop),
    .strobe_o (strobe_o),
    .res_o    (res_o)
  );

  // words of one run leave without gaps
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !res_o.last_word |=> strobe_o)
    else $error("gap inside a word run");

  // every word carries an init or data prefix and the board address
  a_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> ((res_o.bus_word[15:12] == 4'ha) || (res_o.bus_word[15:12] == 4'h9))
                 && (res_o.bus_word[11:8] == BOARD_ADDR))
    else $error("malformed bus word");

  // a transaction on a real channel keeps the converter busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && ((req_i.channel == CH_TX) || (req_i.channel == CH_DEC)) |=> busy)
    else $error("converter not busy after accept");

  // queue never written while full
  a_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat.full |-> !push)
    else $error("queue written while full");

endmodule
